FILE: hdl/aes128_block_cipher_defines.svh
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH
// clocked assertion, disabled while the active-low reset is asserted
`define AES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// assertion that also holds during reset
`define AES_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

FILE: hdl/aes_pkg.sv
package aes_pkg;
    localparam int unsigned NumRounds = 10;
    localparam int unsigned RkAddrW = 4;
    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;
    localparam logic CfgKeyHigh = 1'b0;
    localparam logic CfgKeyLow = 1'b1;

    typedef logic [127:0] t_block;

    typedef struct packed {
        logic             load;
        logic             key_init;
        logic             key_step;
        logic             rk_write;
        logic [RkAddrW-1:0] rk_addr;
        logic             first;
        logic             round;
        logic             last;
        logic             op;
    } t_cmd;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = xtime(x);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 0; i < 254; i++) r = gmul(r, x);
        ginv = r;
    endfunction

    function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
        rotl = (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] r;
        r = ginv(x);
        sbox_calc = r ^ rotl(r, 1) ^ rotl(r, 2) ^ rotl(r, 3) ^ rotl(r, 4) ^ 8'h63;
    endfunction

    typedef logic [7:0] t_box [256];

    function automatic t_box build_fwd();
        t_box t;
        for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
        return t;
    endfunction

    function automatic t_box build_inv();
        t_box t;
        logic [7:0] s;
        for (int i = 0; i < 256; i++) begin
            s = sbox_calc(8'(i));
            t[s] = 8'(i);
        end
        return t;
    endfunction

    localparam t_box FwdBox = build_fwd();
    localparam t_box InvBox = build_inv();
endpackage

FILE: hdl/aes_datapath.sv
module aes_datapath (
    input  logic              i_clk,
    input  aes_pkg::t_cmd     i_cmd,
    input  logic [127:0]      i_block,
    input  logic [127:0]      i_key,
    output logic [127:0]      o_result
);
    logic [127:0] r_state, n_state;
    logic [127:0] r_out;
    logic [127:0] r_kw, n_kw;
    logic [7:0]   r_rcon, n_rcon;
    logic [127:0] rk_mem [11];
    logic [127:0] r_rk;
    logic [127:0] sub, shf, mix, sub_i, shf_i, mix_i, ark;
    logic [31:0]  tw;

    function automatic logic [7:0] bget(input logic [127:0] v, input int i);
        bget = v[127 - 8*i -: 8];
    endfunction

    always_comb begin
        tw = {aes_pkg::FwdBox[r_kw[23:16]] ^ r_rcon, aes_pkg::FwdBox[r_kw[15:8]],
              aes_pkg::FwdBox[r_kw[7:0]], aes_pkg::FwdBox[r_kw[31:24]]};
        n_kw[127:96] = r_kw[127:96] ^ tw;
        n_kw[95:64]  = r_kw[95:64] ^ n_kw[127:96];
        n_kw[63:32]  = r_kw[63:32] ^ n_kw[95:64];
        n_kw[31:0]   = r_kw[31:0] ^ n_kw[63:32];
        n_rcon = aes_pkg::xtime(r_rcon);
        if (i_cmd.key_init) begin
            n_kw = i_key;
            n_rcon = 8'h01;
        end else if (!i_cmd.key_step) begin
            n_kw = r_kw;
            n_rcon = r_rcon;
        end
    end

    always_comb begin
        ark = r_state ^ r_rk;
        for (int i = 0; i < 16; i++)
            sub[127 - 8*i -: 8] = aes_pkg::FwdBox[bget(r_state, i)];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                shf[127 - 8*(4*c + r) -: 8] = bget(sub, 4*((c + r) % 4) + r);
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
            a0 = bget(shf, 4*c); a1 = bget(shf, 4*c+1);
            a2 = bget(shf, 4*c+2); a3 = bget(shf, 4*c+3);
            b0 = bget(ark, 4*c); b1 = bget(ark, 4*c+1);
            b2 = bget(ark, 4*c+2); b3 = bget(ark, 4*c+3);
            mix[127 - 32*c -: 32] = {
                aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3,
                aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3)};
            mix_i[127 - 32*c -: 32] = {
                aes_pkg::gmul(b0, 8'd14) ^ aes_pkg::gmul(b1, 8'd11) ^
                aes_pkg::gmul(b2, 8'd13) ^ aes_pkg::gmul(b3, 8'd9),
                aes_pkg::gmul(b0, 8'd9) ^ aes_pkg::gmul(b1, 8'd14) ^
                aes_pkg::gmul(b2, 8'd11) ^ aes_pkg::gmul(b3, 8'd13),
                aes_pkg::gmul(b0, 8'd13) ^ aes_pkg::gmul(b1, 8'd9) ^
                aes_pkg::gmul(b2, 8'd14) ^ aes_pkg::gmul(b3, 8'd11),
                aes_pkg::gmul(b0, 8'd11) ^ aes_pkg::gmul(b1, 8'd13) ^
                aes_pkg::gmul(b2, 8'd9) ^ aes_pkg::gmul(b3, 8'd14)};
            if (i_cmd.first) mix_i[127 - 32*c -: 32] = ark[127 - 32*c -: 32];
        end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                shf_i[127 - 8*(4*c + r) -: 8] = bget(mix_i, 4*((c + 4 - r) % 4) + r);
        for (int i = 0; i < 16; i++)
            sub_i[127 - 8*i -: 8] = aes_pkg::InvBox[bget(shf_i, i)];
        n_state = r_state;
        if (i_cmd.load) begin
            n_state = i_block;
        end else if (i_cmd.op == aes_pkg::OpEncrypt) begin
            if (i_cmd.first) n_state = ark;
            else if (i_cmd.round) n_state = (i_cmd.last ? shf : mix) ^ r_rk;
        end else begin
            if (i_cmd.last) n_state = ark;
            else if (i_cmd.round) n_state = sub_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_kw <= n_kw;
        r_rcon <= n_rcon;
        if (i_cmd.rk_write) rk_mem[i_cmd.rk_addr] <= r_kw;
        r_rk <= rk_mem[i_cmd.rk_addr];
        if (i_cmd.last) r_out <= n_state;
    end

    assign o_result = r_out;
endmodule

FILE: hdl/aes_ctrl.sv
`include "aes128_block_cipher_defines.svh"
module aes_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_key_changed,
    input  logic          i_in_valid,
    input  logic          i_op,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output aes_pkg::t_cmd o_cmd
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StKey  = 3'd1;
    localparam logic [2:0] StPre  = 3'd2;
    localparam logic [2:0] StRun  = 3'd3;
    localparam logic [2:0] StDone = 3'd4;

    logic [2:0] r_st, n_st;
    logic [3:0] r_cnt, n_cnt;
    logic       r_ready, n_ready;
    logic       r_op, n_op;
    logic       r_ov, n_ov;
    logic [3:0] rk_idx;

    assign o_in_ready = (r_st == StIdle);
    assign o_out_valid = r_ov;

    always_comb begin
        n_st = r_st;
        n_cnt = r_cnt;
        n_ready = r_ready && !i_key_changed;
        n_op = r_op;
        n_ov = r_ov && !i_out_ready;
        o_cmd = '0;
        o_cmd.op = r_op;
        rk_idx = (r_op == aes_pkg::OpEncrypt) ? r_cnt : 4'(aes_pkg::NumRounds) - r_cnt;
        o_cmd.rk_addr = rk_idx;
        case (r_st)
            StIdle: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_op = i_op;
                    n_cnt = '0;
                    o_cmd.key_init = !r_ready;
                    n_st = r_ready ? StPre : StKey;
                    o_cmd.rk_addr = (i_op == aes_pkg::OpEncrypt) ? 4'd0
                                    : 4'(aes_pkg::NumRounds);
                end
            end
            StKey: begin
                o_cmd.rk_write = 1'b1;
                o_cmd.rk_addr = r_cnt;
                o_cmd.key_step = 1'b1;
                if (r_cnt == 4'(aes_pkg::NumRounds)) begin
                    n_ready = 1'b1;
                    n_cnt = '0;
                    n_st = StPre;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            StPre: begin
                n_st = StRun;
            end
            StRun: begin
                if (r_cnt == 4'(aes_pkg::NumRounds)) begin
                    // hold the last round while the output word is still waiting
                    if (!r_ov || i_out_ready) begin
                        o_cmd.round = 1'b1;
                        o_cmd.last = 1'b1;
                        n_st = StIdle;
                        n_ov = 1'b1;
                    end
                end else begin
                    o_cmd.first = (r_cnt == 4'd0);
                    o_cmd.round = 1'b1;
                    o_cmd.rk_addr = (r_op == aes_pkg::OpEncrypt) ? r_cnt + 4'd1
                                    : 4'(aes_pkg::NumRounds) - r_cnt - 4'd1;
                    n_cnt = r_cnt + 4'd1;
                end
            end
            default: n_st = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_cnt <= '0;
            r_ready <= 1'b0;
            r_ov <= 1'b0;
            r_op <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_ready <= n_ready;
            r_ov <= n_ov;
            r_op <= n_op;
        end
    end

    `AES_ASSERT(a_no_accept_busy, (r_st != StIdle) |-> !o_in_ready, "accept while busy")
    `AES_ASSERT(a_out_hold, (r_ov && !i_out_ready) |=> r_ov, "result dropped")
    `AES_ASSERT(a_cnt_range, r_cnt <= 4'(aes_pkg::NumRounds), "round count overflow")
    `AES_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (r_st == StIdle && !r_ov), "reset state")
endmodule

FILE: hdl/aes128_block_cipher.sv
// Each block is loaded on accept and run through the rounds to the result once the round keys
// are ready; key expansion runs before the first block after a key write.
// A new block is accepted only after the previous one has left its rounds; a result waiting
// at the output holds the last round until it is taken.
// Reset: synchronous active low; clears control and marks the round keys stale.
module aes128_block_cipher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_low, block_high
    input  logic         s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // result_low, result_high
);
    logic [63:0] r_key_hi, r_key_lo;
    aes_pkg::t_cmd cmd;
    logic [127:0] result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == aes_pkg::CfgKeyHigh) r_key_hi <= i_cfg_data;
            else r_key_lo <= i_cfg_data;
        end
    end

    aes_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key_changed(i_cfg_we),
        .i_in_valid(s_axis_tvalid), .i_op(s_axis_tuser), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .o_cmd(cmd)
    );

    aes_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd),
        .i_block({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .i_key({r_key_hi, r_key_lo}), .o_result(result)
    );

    assign m_axis_tdata = {result[63:0], result[127:64]};
endmodule
